@@ src/pase_pkg.sv @@
// Package for the parenthesized add/subtract evaluator.
// Holds the nesting limit, the command passed from front end to back end and the error codes.
// Depends on nothing.
package pase_pkg;

  localparam int MaxNest = 16;
  localparam int DepthW = (MaxNest > 2) ? $clog2(MaxNest) : 1;

  typedef logic [DepthW-1:0] depth_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PLUS,
    OP_MINUS,
    OP_OPEN,
    OP_CLOSE
  } op_e;

  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrMissingOp = 3'd1;
  localparam logic [2:0] ErrTooDeep   = 3'd2;
  localparam logic [2:0] ErrUnmatched = 3'd3;
  localparam logic [2:0] ErrUnclosed  = 3'd4;

  typedef struct packed {
    logic        num_valid;
    logic [31:0] num;
    op_e         op;
    logic        last;
  } cmd_t;

endpackage

@@ src/paren_add_sub_evaluator_top.sv @@
// Top level of the parenthesized add/subtract evaluator.
// Depends on pase_pkg, pase_front, pase_queue and pase_back.
//
// The input channel carries one ASCII character per transfer (in_symbol_i) with
// in_last_i marking the final character of an expression. Digits build numbers;
// '+', '-', '(' and ')' are operators and every other character only ends a number.
// The output channel carries one transfer per expression: the 32-bit wrapping
// value and the first error code seen (0 ok, 1 missing operator, 2 too deep,
// 3 unmatched close, 4 unclosed open).
// Throughput is one character per cycle while in_stall_o is low. The front end
// pushes each command into a two-entry queue; the back end executes one per cycle
// unless a last command waits on a stalled result. out_valid_o is registered and
// rises once the last character's command, behind any waiting ones, has executed.
// When the receiver stalls, the result is held; the back end keeps executing
// commands until it reaches the next last character, after which the queue
// fills and in_stall_o rises.
// Reset clears the queue, the gathered number, the nesting depth and the error,
// and the next character starts a new expression.
module paren_add_sub_evaluator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  in_symbol_i,
  input  logic        in_last_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_value_o,
  output logic [2:0]  out_error_o
);
  import pase_pkg::*;

  logic full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic cmd_valid;
  cmd_t cmd;

  pase_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_symbol_i (in_symbol_i),
    .in_last_i   (in_last_i),
    .in_stall_o  (in_stall_o),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  pase_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd)
  );

  pase_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_value_o (out_value_o),
    .out_error_o (out_error_o)
  );

endmodule

@@ src/pase_front.sv @@
// Front end of the evaluator: accepts characters, gathers decimal numbers and
// classifies each character into a command for the back end. Depends on pase_pkg.
module pase_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_symbol_i,
  input  logic          in_last_i,
  output logic          in_stall_o,
  input  logic          full_i,
  output logic          push_o,
  output pase_pkg::cmd_t cmd_o
);
  import pase_pkg::*;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharOpen  = 8'h28;
  localparam logic [7:0] CharClose = 8'h29;

  logic [31:0] acc_q, acc_d;
  logic        in_num_q;
  logic        accept;
  logic        is_digit;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept;
  assign is_digit   = (in_symbol_i >= CharZero) && (in_symbol_i <= CharNine);

  // Multiply by ten as two shifts and an add.
  assign acc_d = (acc_q << 3) + (acc_q << 1) + {28'd0, in_symbol_i[3:0]};

  always_comb begin
    cmd_o.last = in_last_i;
    if (is_digit) begin
      cmd_o.num_valid = in_last_i;
      cmd_o.num       = acc_d;
      cmd_o.op        = OP_NONE;
    end else begin
      cmd_o.num_valid = in_num_q;
      cmd_o.num       = acc_q;
      unique case (in_symbol_i)
        CharPlus:  cmd_o.op = OP_PLUS;
        CharMinus: cmd_o.op = OP_MINUS;
        CharOpen:  cmd_o.op = OP_OPEN;
        CharClose: cmd_o.op = OP_CLOSE;
        default:   cmd_o.op = OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      in_num_q <= 1'b0;
    end else if (accept) begin
      if (is_digit && !in_last_i) begin
        acc_q    <= acc_d;
        in_num_q <= 1'b1;
      end else begin
        acc_q    <= '0;
        in_num_q <= 1'b0;
      end
    end
  end

endmodule

@@ src/pase_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on pase_pkg for the command type.
module pase_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pase_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pase_pkg::cmd_t cmd_o
);
  import pase_pkg::*;

  cmd_t       data_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = data_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ src/pase_back.sv @@
// Back end of the evaluator: executes one command per cycle against the level stack,
// unless a last command waits on a stalled result, and holds the result in an output register. Depends on pase_pkg.
module pase_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  pase_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    out_value_o,
  output logic [2:0]     out_error_o
);
  import pase_pkg::*;

  typedef enum logic [1:0] {
    MODE_PLUS,
    MODE_MINUS,
    MODE_NONE
  } mode_e;

  // The current level lives in registers; the levels below it live in the stack.
  logic [31:0] cur_sum_q, cur_sum_d;
  mode_e       cur_mode_q, cur_mode_d;
  depth_t      depth_q, depth_d;
  logic [2:0]  err_q, err_d;
  logic [31:0] stk_sum_q  [MaxNest-1];
  mode_e       stk_mode_q [MaxNest-1];

  logic        out_valid_q;
  logic [31:0] out_value_q;
  logic [2:0]  out_error_q;

  logic        exec;
  logic        push_en;
  depth_t      parent_idx;
  logic [31:0] sum_a;
  mode_e       mode_a;
  logic [31:0] parent_sum;
  mode_e       parent_mode;
  logic [31:0] level0;

  assign exec        = cmd_valid_i && (!cmd_i.last || !out_valid_q || !out_stall_i);
  assign pop_o       = exec;
  assign parent_idx  = depth_q - depth_t'(1);
  assign parent_sum  = stk_sum_q[parent_idx];
  assign parent_mode = stk_mode_q[parent_idx];

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_error_o = out_error_q;

  always_comb begin
    sum_a      = cur_sum_q;
    mode_a     = cur_mode_q;
    err_d      = err_q;
    push_en    = 1'b0;
    if (cmd_i.num_valid) begin
      mode_a = MODE_NONE;
      unique case (cur_mode_q)
        MODE_PLUS:  sum_a = cur_sum_q + cmd_i.num;
        MODE_MINUS: sum_a = cur_sum_q - cmd_i.num;
        default: begin
          if (err_d == ErrNone) err_d = ErrMissingOp;
        end
      endcase
    end

    cur_sum_d  = sum_a;
    cur_mode_d = mode_a;
    depth_d    = depth_q;
    unique case (cmd_i.op)
      OP_PLUS:  cur_mode_d = MODE_PLUS;
      OP_MINUS: cur_mode_d = MODE_MINUS;
      OP_OPEN: begin
        if (depth_q == depth_t'(MaxNest - 1)) begin
          if (err_d == ErrNone) err_d = ErrTooDeep;
        end else begin
          push_en    = 1'b1;
          cur_sum_d  = '0;
          cur_mode_d = MODE_PLUS;
          depth_d    = depth_q + depth_t'(1);
        end
      end
      OP_CLOSE: begin
        if (depth_q == '0) begin
          if (err_d == ErrNone) err_d = ErrUnmatched;
        end else begin
          depth_d    = parent_idx;
          cur_mode_d = MODE_NONE;
          unique case (parent_mode)
            MODE_PLUS:  cur_sum_d = parent_sum + sum_a;
            MODE_MINUS: cur_sum_d = parent_sum - sum_a;
            default: begin
              cur_sum_d = parent_sum;
              if (err_d == ErrNone) err_d = ErrMissingOp;
            end
          endcase
        end
      end
      default: ;
    endcase

    if (depth_d == '0) begin
      level0 = cur_sum_d;
    end else if (depth_q == '0) begin
      level0 = sum_a;
    end else begin
      level0 = stk_sum_q[0];
    end

    if (cmd_i.last && (depth_d != '0) && (err_d == ErrNone)) begin
      err_d = ErrUnclosed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && push_en) begin
      stk_sum_q[depth_q]  <= sum_a;
      stk_mode_q[depth_q] <= mode_a;
    end
    if (exec && cmd_i.last) begin
      out_value_q <= level0;
      out_error_q <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_sum_q   <= '0;
      cur_mode_q  <= MODE_PLUS;
      depth_q     <= '0;
      err_q       <= ErrNone;
      out_valid_q <= 1'b0;
    end else begin
      if (exec && cmd_i.last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (exec) begin
        if (cmd_i.last) begin
          cur_sum_q   <= '0;
          cur_mode_q  <= MODE_PLUS;
          depth_q     <= '0;
          err_q       <= ErrNone;
        end else begin
          cur_sum_q  <= cur_sum_d;
          cur_mode_q <= cur_mode_d;
          depth_q    <= depth_d;
          err_q      <= err_d;
        end
      end
    end
  end

endmodule

@@ src/pase_checker.sv @@
// Port-level checker for the evaluator, attached to the top level by a bind.
// Depends on pase_pkg and paren_add_sub_evaluator_top.
module pase_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_value_o,
  input logic [2:0]  out_error_o
);
  import pase_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled result was dropped.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_value_o) && $stable(out_error_o))
    else $error("Stalled result changed.");

  a_error_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_error_o <= ErrUnclosed)
    else $error("Error code out of range.");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !in_stall_o)
    else $error("Input stalled although the output register was free.");

endmodule

bind paren_add_sub_evaluator_top pase_checker u_pase_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_value_o (out_value_o),
  .out_error_o (out_error_o)
);

@@ bench/paren_add_sub_evaluator_top_test.sv @@
// Testbench for the parenthesized add/subtract evaluator, with directed and random expressions.
// A queue-fed driver, a stall pattern on the result side and a self-kept expression model.
// Depends on pase_pkg and paren_add_sub_evaluator_top.
module paren_add_sub_evaluator_top_test;
  import pase_pkg::*;

  typedef enum logic [1:0] {
    SIGN_PLUS,
    SIGN_MINUS,
    SIGN_NONE
  } sign_e;

  typedef struct {
    logic [7:0] symbol;
    logic       last;
    bit         drain;
  } symbol_item_t;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  error;
  } eval_result_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam string      Meaningful = "0123456789+-() ";

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  in_symbol_i = 8'h00;
  logic        in_last_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] out_value_o;
  logic [2:0]  out_error_o;

  symbol_item_t pending_q[$];
  eval_result_t results_q[$];
  logic [7:0]   draft_q[$];

  logic [31:0] acc_r;
  bit          in_num_r;
  logic [31:0] sum_r [MaxNest];
  sign_e       mode_r [MaxNest];
  int          depth_r;
  logic [2:0]  err_r;

  bit sym_taken = 1'b0;
  int n_taken = 0;
  int n_errors = 0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int seg_left = 0;
  int stall_mode = 0;

  paren_add_sub_evaluator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_symbol_i(in_symbol_i),
    .in_last_i  (in_last_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_value_o(out_value_o),
    .out_error_o(out_error_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0h, want %0h", what, got, want);
    n_errors++;
  endtask

  task automatic note_error(input logic [2:0] code);
    if (err_r == ErrNone) err_r = code;
  endtask

  function automatic int top_level();
    return (depth_r < MaxNest) ? depth_r : 0;
  endfunction

  task automatic fold_into_level(input logic [31:0] v);
    int t;
    t = top_level();
    case (mode_r[t])
      SIGN_PLUS:  sum_r[t] = sum_r[t] + v;
      SIGN_MINUS: sum_r[t] = sum_r[t] - v;
      default:    note_error(ErrMissingOp);
    endcase
    mode_r[t] = SIGN_NONE;
  endtask

  task automatic close_number();
    if (in_num_r) begin
      fold_into_level(acc_r);
      acc_r = '0;
      in_num_r = 1'b0;
    end
  endtask

  task automatic clear_expression();
    acc_r = '0;
    in_num_r = 1'b0;
    depth_r = 0;
    err_r = ErrNone;
    sum_r[0] = '0;
    mode_r[0] = SIGN_PLUS;
  endtask

  task automatic evaluate_symbol(input logic [7:0] sym, input logic lst);
    logic [31:0] inner;
    eval_result_t res;
    if (sym >= CH_ZERO && sym <= CH_NINE) begin
      acc_r = acc_r * 32'd10 + 32'(sym - CH_ZERO);
      in_num_r = 1'b1;
    end else begin
      close_number();
      case (sym)
        CH_PLUS:  mode_r[top_level()] = SIGN_PLUS;
        CH_MINUS: mode_r[top_level()] = SIGN_MINUS;
        CH_OPEN: begin
          if (depth_r + 1 >= MaxNest) begin
            note_error(ErrTooDeep);
          end else begin
            depth_r++;
            sum_r[depth_r] = '0;
            mode_r[depth_r] = SIGN_PLUS;
          end
        end
        CH_CLOSE: begin
          if (depth_r == 0) begin
            note_error(ErrUnmatched);
          end else begin
            inner = sum_r[top_level()];
            depth_r--;
            fold_into_level(inner);
          end
        end
        default: ;
      endcase
    end
    if (lst) begin
      close_number();
      if (depth_r != 0) note_error(ErrUnclosed);
      res.value = sum_r[0];
      res.error = err_r;
      results_q.insert(results_q.size(), res);
      clear_expression();
    end
  endtask

  task automatic add_symbol(input logic [7:0] s, input logic l, input bit d);
    symbol_item_t item;
    item.symbol = s;
    item.last = l;
    item.drain = d;
    pending_q.insert(pending_q.size(), item);
  endtask

  task automatic add_text(input string txt);
    for (int i = 0; i < txt.len(); i++) add_symbol(txt[i], i == txt.len() - 1, 1'b0);
  endtask

  task automatic draft_number();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
    repeat (n) draft_q.insert(draft_q.size(), CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic draft_sign();
    draft_q.insert(draft_q.size(), $urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
  endtask

  task automatic draft_expression();
    int style;
    int depth;
    int max_depth;
    int terms;
    int pos;
    bit need_operand;
    draft_q.delete();
    style = $urandom_range(0, 9);
    if (style == 8) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 1)) begin
          draft_q.insert(draft_q.size(), 8'($urandom_range(0, 255)));
        end else begin
          draft_q.insert(draft_q.size(), Meaningful[$urandom_range(0, Meaningful.len() - 1)]);
        end
      end
    end else begin
      max_depth = (style == 9) ? $urandom_range(14, 18) : $urandom_range(0, 4);
      terms = $urandom_range(1, 8);
      depth = 0;
      need_operand = 1'b1;
      if ($urandom_range(0, 3) == 0) draft_sign();
      while (terms > 0 || depth > 0 || need_operand) begin
        if (need_operand) begin
          if (depth < max_depth && $urandom_range(0, 2) == 0) begin
            draft_q.insert(draft_q.size(), CH_OPEN);
            depth++;
            if ($urandom_range(0, 4) == 0) draft_sign();
          end else begin
            draft_number();
            need_operand = 1'b0;
            terms--;
          end
        end else if (depth > 0 && (terms == 0 || $urandom_range(0, 2) == 0)) begin
          draft_q.insert(draft_q.size(), CH_CLOSE);
          depth--;
        end else begin
          draft_sign();
          need_operand = 1'b1;
        end
        if ($urandom_range(0, 7) == 0) draft_q.insert(draft_q.size(), CH_SPACE);
      end
      if (style == 7) begin
        pos = $urandom_range(0, draft_q.size() - 1);
        case ($urandom_range(0, 2))
          0: if (draft_q.size() > 1) draft_q.delete(pos);
          1: draft_q.insert(pos, Meaningful[$urandom_range(0, Meaningful.len() - 1)]);
          default: draft_q.push_front($urandom_range(0, 1) ? CH_CLOSE : CH_OPEN);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    int n_random;
    int pauses;
    bit drain;
    clear_expression();
    repeat (16) add_symbol(CH_OPEN, 1'b0, 1'b0);
    add_text("7");
    add_text(")");
    add_text("9-(2+3)4");
    add_text("(1");
    add_symbol(8'h00, 1'b0, 1'b0);
    add_symbol(8'hff, 1'b0, 1'b0);
    add_text("2147483648-1");
    n_random = 0;
    pauses = 0;
    while (n_random < 1900) begin
      draft_expression();
      drain = (pauses < 2 && n_random >= 600 + pauses * 700);
      if (drain) pauses++;
      foreach (draft_q[i]) add_symbol(draft_q[i], i == draft_q.size() - 1, drain && i == 0);
      n_random += draft_q.size();
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(negedge clk_i) begin : drive_symbols
    symbol_item_t nxt;
    if (rst_ni && (!in_valid_i || sym_taken)) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && results_q.size() != 0)) begin
        nxt = pending_q.pop_front();
        in_valid_i <= 1'b1;
        in_symbol_i <= nxt.symbol;
        in_last_i <= nxt.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : drive_stall
    if (rst_ni) begin
      if (seg_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        seg_left <= $urandom_range(8, 80);
      end else begin
        seg_left <= seg_left - 1;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (holds_done < 2 && n_taken >= 500 + holds_done * 900) begin
        out_stall_i <= 1'b1;
        hold_left <= 400;
        holds_done <= holds_done + 1;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= 1'($urandom_range(0, 1));
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : watch_transfers
    eval_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (results_q.size() == 0) begin
          report_mismatch("unexpected result", out_value_o, 32'h0);
        end else begin
          want = results_q.pop_front();
          if (out_value_o !== want.value) report_mismatch("value", out_value_o, want.value);
          if (out_error_o !== want.error) begin
            report_mismatch("error", 32'(out_error_o), 32'(want.error));
          end
        end
      end
      sym_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        evaluate_symbol(in_symbol_i, in_last_i);
        n_taken++;
      end
    end
  end

endmodule

@@ filelist.f @@
src/pase_pkg.sv
src/pase_front.sv
src/pase_queue.sv
src/pase_back.sv
src/paren_add_sub_evaluator_top.sv
src/pase_checker.sv
bench/paren_add_sub_evaluator_top_test.sv
